FILE: rtl/fcp_pkg.sv
// shared types and constants of the font chunk header parser
package fcp_pkg;

   localparam logic [31:0] MAGIC_TAG = 32'h54494643;

   localparam logic [1:0] KIND_TAGS  = 2'd0;
   localparam logic [1:0] KIND_GLYPH = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   localparam logic [2:0] ERR_NONE     = 3'd0;
   localparam logic [2:0] ERR_TAG      = 3'd1;
   localparam logic [2:0] ERR_RESERVED = 3'd2;
   localparam logic [2:0] ERR_INDEX    = 3'd3;
   localparam logic [2:0] ERR_LENGTH   = 3'd4;
   localparam logic [2:0] ERR_TABLES   = 3'd5;
   localparam logic [2:0] ERR_OVERFLOW = 3'd6;

   localparam logic CSR_EXPECTED_INDEX = 1'b0;
   localparam logic CSR_CHUNK_LENGTH   = 1'b1;

   typedef enum logic [3:0] {
      PH_MAGIC    = 4'd0,
      PH_RESERVED = 4'd1,
      PH_IDS      = 4'd2,
      PH_INDEX    = 4'd3,
      PH_LENGTH   = 4'd4,
      PH_COUNT    = 4'd5,
      PH_TABLES   = 4'd6,
      PH_GIDS     = 4'd7,
      PH_TAG1     = 4'd8,
      PH_TAG2     = 4'd9,
      PH_START    = 4'd10,
      PH_OFFS1    = 4'd11,
      PH_OFFS2    = 4'd12,
      PH_DONE     = 4'd13
   } fcp_phase_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] glyph_id;
      logic        table_select;
      logic [31:0] first_tag;
      logic [31:0] second_tag;
      logic [31:0] byte_offset;
      logic [31:0] byte_length;
      logic [2:0]  error_code;
      logic        final_record;
   } fcp_result_type;

endpackage

FILE: rtl/font_chunk_header_parser.sv
// Font chunk header parser, top level.
// Bytes of a chunk enter on the req_ channel, one beat per byte, with
// req_end_of_chunk high on the last byte. Results leave on the rsp_ channel:
// one table-tags result, then one glyph record per end offset, or a single
// error result whose error_code names the failed check; a chunk cut short
// also ends in an error result. Results reach rsp_ through the output buffer.
// Throughput is one byte per cycle while req_stall is low: each byte passes
// one field-assembly and check stage; the glyph id is read from the id store
// in earlier bytes of its offset field, so its single read port keeps up.
// Results sit in an output register backed by one skid stage; req_stall
// rises only while both hold results, i.e. after the receiver has stalled.
// Reset clears the configuration registers and restarts the parse at the
// magic tag; the id store is not cleared and needs no clearing pass.
// csr_ writes set the expected chunk index and chunk length; the user must
// make them only while no chunk is in flight; the block does not enforce it.
module font_chunk_header_parser #(
   parameter int MAX_GLYPHS = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_byte_value,
   input  logic        req_end_of_chunk,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [15:0] rsp_glyph_id,
   output logic        rsp_table_select,
   output logic [31:0] rsp_first_tag,
   output logic [31:0] rsp_second_tag,
   output logic [31:0] rsp_byte_offset,
   output logic [31:0] rsp_byte_length,
   output logic [2:0]  rsp_error_code,
   output logic        rsp_final_record,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [31:0] csr_write_data
);
   import fcp_pkg::*;

   logic [15:0]    expected_index_ff, expected_index_in;
   logic [31:0]    chunk_length_ff, chunk_length_in;
   logic           beat;
   logic           push_valid;
   fcp_result_type push_result;
   fcp_result_type out_result;
   logic           buf_full;

   always_comb begin
      expected_index_in = expected_index_ff;
      chunk_length_in   = chunk_length_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_EXPECTED_INDEX: expected_index_in = csr_write_data[15:0];
            CSR_CHUNK_LENGTH:   chunk_length_in   = csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_index_ff <= '0;
         chunk_length_ff   <= '0;
      end else begin
         expected_index_ff <= expected_index_in;
         chunk_length_ff   <= chunk_length_in;
      end
   end

   assign req_stall = buf_full;
   assign beat      = req_valid && !buf_full;

   fcp_parser #(
      .MAX_GLYPHS(MAX_GLYPHS)
   ) u_parser (
      .clock         (clock),
      .reset         (reset),
      .beat          (beat),
      .byte_value    (req_byte_value),
      .end_of_chunk  (req_end_of_chunk),
      .expected_index(expected_index_ff),
      .chunk_length  (chunk_length_ff),
      .push_valid    (push_valid),
      .push_result   (push_result)
   );

   fcp_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_result(push_result),
      .full       (buf_full),
      .out_valid  (rsp_valid),
      .out_stall  (rsp_stall),
      .out_result (out_result)
   );

   assign rsp_kind         = out_result.kind;
   assign rsp_glyph_id     = out_result.glyph_id;
   assign rsp_table_select = out_result.table_select;
   assign rsp_first_tag    = out_result.first_tag;
   assign rsp_second_tag   = out_result.second_tag;
   assign rsp_byte_offset  = out_result.byte_offset;
   assign rsp_byte_length  = out_result.byte_length;
   assign rsp_error_code   = out_result.error_code;
   assign rsp_final_record = out_result.final_record;

endmodule

FILE: rtl/fcp_ram.sv
// generic single write port ram with registered read
module fcp_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024,
   parameter int ADDR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                  clock,
   input  logic                  write_enable,
   input  logic [ADDR_WIDTH-1:0] write_addr,
   input  logic [WIDTH-1:0]      write_data,
   input  logic [ADDR_WIDTH-1:0] read_addr,
   output logic [WIDTH-1:0]      read_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem[write_addr] <= write_data;
      end
      read_data_ff <= mem[read_addr];
   end

   assign read_data = read_data_ff;

endmodule

FILE: rtl/fcp_parser.sv
// byte-wise header parser: field assembly, checks, id store and result build
module fcp_parser #(
   parameter int MAX_GLYPHS = 1024
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   beat,
   input  logic [7:0]             byte_value,
   input  logic                   end_of_chunk,
   input  logic [15:0]            expected_index,
   input  logic [31:0]            chunk_length,
   output logic                   push_valid,
   output fcp_pkg::fcp_result_type push_result
);
   import fcp_pkg::*;

   localparam int PW = $clog2(MAX_GLYPHS + 1);
   localparam int AW = (MAX_GLYPHS > 1) ? $clog2(MAX_GLYPHS) : 1;

   fcp_phase_type  phase_ff, phase_in;
   logic [1:0]     byte_in_field_ff, byte_in_field_in;
   logic [23:0]    field_shift_ff, field_shift_in;
   logic [1:0]     ids_word_ff, ids_word_in;
   logic [PW-1:0]  glyph_total_ff, glyph_total_in;
   logic [PW-1:0]  glyph_position_ff, glyph_position_in;
   logic           two_tables_ff, two_tables_in;
   logic [31:0]    table_one_tag_ff, table_one_tag_in;
   logic [31:0]    previous_offset_ff, previous_offset_in;
   logic           error_seen_ff, error_seen_in;

   logic [31:0]    field_value;
   logic           active;
   logic           complete;
   logic [PW:0]    position_next;
   logic           position_last;
   logic           raise;
   logic [2:0]     raise_code;
   logic           store_write;
   logic [15:0]    store_data;
   logic           table_bit;
   fcp_result_type result;
   logic           result_valid;

   fcp_ram #(
      .WIDTH(16),
      .DEPTH(MAX_GLYPHS),
      .ADDR_WIDTH(AW)
   ) u_id_store (
      .clock       (clock),
      .write_enable(store_write),
      .write_addr  (glyph_position_ff[AW-1:0]),
      .write_data  (field_value[15:0]),
      .read_addr   (glyph_position_ff[AW-1:0]),
      .read_data   (store_data)
   );

   assign field_value   = {field_shift_ff, byte_value};
   assign active        = !error_seen_ff && (phase_ff != PH_DONE);
   assign position_next = {1'b0, glyph_position_ff} + {{PW{1'b0}}, 1'b1};
   assign position_last = position_next >= {1'b0, glyph_total_ff};
   assign table_bit     = (phase_ff == PH_OFFS2);

   always_comb begin
      case (phase_ff)
         PH_TABLES: complete = 1'b1;
         PH_GIDS:   complete = byte_in_field_ff[0];
         default:   complete = (byte_in_field_ff == 2'd3);
      endcase
   end

   always_comb begin
      phase_in           = phase_ff;
      byte_in_field_in   = byte_in_field_ff;
      field_shift_in     = field_shift_ff;
      ids_word_in        = ids_word_ff;
      glyph_total_in     = glyph_total_ff;
      glyph_position_in  = glyph_position_ff;
      two_tables_in      = two_tables_ff;
      table_one_tag_in   = table_one_tag_ff;
      previous_offset_in = previous_offset_ff;
      error_seen_in      = error_seen_ff;
      raise              = 1'b0;
      raise_code         = ERR_NONE;
      store_write        = 1'b0;
      result             = '0;
      result_valid       = 1'b0;

      if (beat && active) begin
         if (!complete) begin
            byte_in_field_in = byte_in_field_ff + 2'd1;
            field_shift_in   = field_value[23:0];
         end else begin
            byte_in_field_in = 2'd0;
            field_shift_in   = '0;
            case (phase_ff)
               PH_MAGIC: begin
                  if (field_value != MAGIC_TAG) begin
                     raise      = 1'b1;
                     raise_code = ERR_TAG;
                  end else begin
                     phase_in = PH_RESERVED;
                  end
               end
               PH_RESERVED: begin
                  if (field_value != 32'd0) begin
                     raise      = 1'b1;
                     raise_code = ERR_RESERVED;
                  end else begin
                     phase_in    = PH_IDS;
                     ids_word_in = 2'd0;
                  end
               end
               PH_IDS: begin
                  ids_word_in = ids_word_ff + 2'd1;
                  if (ids_word_ff == 2'd3) begin
                     phase_in = PH_INDEX;
                  end
               end
               PH_INDEX: begin
                  if (field_value != {16'd0, expected_index}) begin
                     raise      = 1'b1;
                     raise_code = ERR_INDEX;
                  end else begin
                     phase_in = PH_LENGTH;
                  end
               end
               PH_LENGTH: begin
                  if (field_value != chunk_length) begin
                     raise      = 1'b1;
                     raise_code = ERR_LENGTH;
                  end else begin
                     phase_in = PH_COUNT;
                  end
               end
               PH_COUNT: begin
                  if (field_value > 32'(MAX_GLYPHS)) begin
                     raise      = 1'b1;
                     raise_code = ERR_OVERFLOW;
                  end else begin
                     glyph_total_in = field_value[PW-1:0];
                     phase_in       = PH_TABLES;
                  end
               end
               PH_TABLES: begin
                  if (field_value != 32'd1 && field_value != 32'd2) begin
                     raise      = 1'b1;
                     raise_code = ERR_TABLES;
                  end else begin
                     two_tables_in     = (field_value == 32'd2);
                     glyph_position_in = '0;
                     phase_in = (glyph_total_ff == '0) ? PH_TAG1 : PH_GIDS;
                  end
               end
               PH_GIDS: begin
                  store_write = 1'b1;
                  if (position_last) begin
                     glyph_position_in = '0;
                     phase_in          = PH_TAG1;
                  end else begin
                     glyph_position_in = position_next[PW-1:0];
                  end
               end
               PH_TAG1: begin
                  table_one_tag_in = field_value;
                  if (two_tables_ff) begin
                     phase_in = PH_TAG2;
                  end else begin
                     result_valid     = 1'b1;
                     result.kind      = KIND_TAGS;
                     result.first_tag = field_value;
                     phase_in         = PH_START;
                  end
               end
               PH_TAG2: begin
                  result_valid      = 1'b1;
                  result.kind       = KIND_TAGS;
                  result.first_tag  = table_one_tag_ff;
                  result.second_tag = field_value;
                  phase_in          = PH_START;
               end
               PH_START: begin
                  previous_offset_in = field_value;
                  glyph_position_in  = '0;
                  phase_in = (glyph_total_ff == '0) ? PH_DONE : PH_OFFS1;
               end
               PH_OFFS1, PH_OFFS2: begin
                  // id read was issued during the earlier bytes of this offset
                  result_valid        = 1'b1;
                  result.kind         = KIND_GLYPH;
                  result.glyph_id     = store_data;
                  result.table_select = table_bit;
                  result.byte_offset  = previous_offset_ff;
                  result.byte_length  = field_value - previous_offset_ff;
                  result.final_record = position_last && (table_bit || !two_tables_ff);
                  previous_offset_in  = field_value;
                  if (position_last) begin
                     glyph_position_in = '0;
                     phase_in = (!table_bit && two_tables_ff) ? PH_OFFS2 : PH_DONE;
                  end else begin
                     glyph_position_in = position_next[PW-1:0];
                  end
               end
               default: phase_in = PH_DONE;
            endcase
         end
      end

      if (raise) begin
         result              = '0;
         result_valid        = 1'b1;
         result.kind         = KIND_ERROR;
         result.error_code   = raise_code;
         result.final_record = 1'b1;
         error_seen_in       = 1'b1;
      end

      if (beat && end_of_chunk) begin
         // truncated chunk result replaces any non-error result of this beat
         if (!error_seen_ff && !error_seen_in && phase_in != PH_DONE) begin
            result              = '0;
            result_valid        = 1'b1;
            result.kind         = KIND_ERROR;
            result.error_code   = ERR_OVERFLOW;
            result.final_record = 1'b1;
         end
         phase_in           = PH_MAGIC;
         byte_in_field_in   = 2'd0;
         field_shift_in     = '0;
         ids_word_in        = 2'd0;
         glyph_total_in     = '0;
         glyph_position_in  = '0;
         two_tables_in      = 1'b0;
         table_one_tag_in   = '0;
         previous_offset_in = '0;
         error_seen_in      = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff           <= PH_MAGIC;
         byte_in_field_ff   <= 2'd0;
         field_shift_ff     <= '0;
         ids_word_ff        <= 2'd0;
         glyph_total_ff     <= '0;
         glyph_position_ff  <= '0;
         two_tables_ff      <= 1'b0;
         table_one_tag_ff   <= '0;
         previous_offset_ff <= '0;
         error_seen_ff      <= 1'b0;
      end else begin
         phase_ff           <= phase_in;
         byte_in_field_ff   <= byte_in_field_in;
         field_shift_ff     <= field_shift_in;
         ids_word_ff        <= ids_word_in;
         glyph_total_ff     <= glyph_total_in;
         glyph_position_ff  <= glyph_position_in;
         two_tables_ff      <= two_tables_in;
         table_one_tag_ff   <= table_one_tag_in;
         previous_offset_ff <= previous_offset_in;
         error_seen_ff      <= error_seen_in;
      end
   end

   assign push_valid  = result_valid;
   assign push_result = result;

`ifndef SYNTH
   a_quiet_after_error: assert property (@(posedge clock) disable iff (reset)
      beat && error_seen_ff |-> !push_valid)
      else $error("result produced after a sticky error");

   a_error_is_final: assert property (@(posedge clock) disable iff (reset)
      push_valid && push_result.kind == KIND_ERROR |->
         push_result.final_record && push_result.error_code != ERR_NONE)
      else $error("error result without code or final mark");

   a_total_bounded: assert property (@(posedge clock) disable iff (reset)
      {1'b0, glyph_total_ff} <= (PW+1)'(MAX_GLYPHS) &&
      glyph_position_ff <= glyph_total_ff)
      else $error("glyph counters out of range");
`endif

endmodule

FILE: rtl/fcp_out_buf.sv
// two-deep result buffer: output register plus skid stage
module fcp_out_buf (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push_valid,
   input  fcp_pkg::fcp_result_type push_result,
   output logic                   full,
   output logic                   out_valid,
   input  logic                   out_stall,
   output fcp_pkg::fcp_result_type out_result
);
   import fcp_pkg::*;

   logic           out_valid_ff, out_valid_in;
   logic           skid_valid_ff, skid_valid_in;
   fcp_result_type out_data_ff, out_data_in;
   fcp_result_type skid_data_ff, skid_data_in;
   logic           out_take;

   assign out_take = out_valid_ff && !out_stall;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (out_take) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push_valid) begin
         if (!out_valid_ff || out_take) begin
            out_data_in  = push_result;
            out_valid_in = 1'b1;
         end else begin
            skid_data_in  = push_result;
            skid_valid_in = 1'b1;
         end
      end else if (out_take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign full       = skid_valid_ff;
   assign out_valid  = out_valid_ff;
   assign out_result = out_data_ff;

`ifndef SYNTH
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid stage holds a beat while output register is empty");

   a_skid_kept: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && !out_take |=> skid_valid_ff)
      else $error("skid beat lost while output stalled");

   a_push_shows: assert property (@(posedge clock) disable iff (reset)
      push_valid && !full |=> out_valid_ff)
      else $error("pushed result did not reach the output");
`endif

endmodule
